// ===== design/rdfb_pkg.sv =====
// Shared types, constants and the CRC bit step for the rail decoder frame builder.
`default_nettype none

package rdfb_pkg;

  // Widths of the assembled frame and its bookkeeping.
  localparam int FRAME_W    = 72;
  localparam int LEN_W      = 7;
  localparam int CRC_W      = 8;
  localparam int CHUNK_W    = 8;
  localparam int CNT_W      = 4;
  localparam int CRC_STAGES = FRAME_W / CHUNK_W;

  // CRC and frame constants.
  localparam logic [CRC_W-1:0] CRC_INIT    = 8'h7F;
  localparam logic [CRC_W-1:0] CRC_POLY    = 8'h07;
  localparam logic [5:0]       CMD_STATION = 6'h3D;
  localparam logic [5:0]       CMD_SID     = 6'h3B;
  localparam logic [7:0]       BCAST_MARK  = 8'h80;

  // Frame lengths in bits, without the CRC.
  localparam logic [LEN_W-1:0] DRIVE_BITS   = 7'd40;
  localparam logic [LEN_W-1:0] STATION_BITS = 7'd63;
  localparam logic [LEN_W-1:0] SID_BITS     = 7'd61;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_DRIVE   = 2'd0,
    REQ_STATION = 2'd1,
    REQ_SID     = 2'd2
  } req_t;

  // A frame on its way through the CRC pipeline.
  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic [CRC_W-1:0]   crc;
  } frame_t;

  // Shift one bit into the CRC register.
  function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                               input logic din);
    logic [CRC_W-1:0] shifted;
    shifted = {crc[CRC_W-2:0], din};
    return crc[CRC_W-1] ? (shifted ^ CRC_POLY) : shifted;
  endfunction

endpackage

`default_nettype wire

// ===== design/rdfb_crc_pipe.sv =====
// Nine-stage CRC pipeline, eight frame bits per stage, with per-stage valid bits.
`default_nettype none

module rdfb_crc_pipe (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire rdfb_pkg::frame_t in_frame,
  output logic                 in_ready,
  output logic                 out_valid,
  output rdfb_pkg::frame_t     out_frame,
  input  wire logic            out_ready
);

  logic [rdfb_pkg::CRC_STAGES-1:0] stg_valid;
  rdfb_pkg::frame_t                stg_frame [rdfb_pkg::CRC_STAGES];
  rdfb_pkg::frame_t                stg_next  [rdfb_pkg::CRC_STAGES];
  logic [rdfb_pkg::CRC_STAGES-1:0] src_valid;
  rdfb_pkg::frame_t                src_frame [rdfb_pkg::CRC_STAGES];
  logic [rdfb_pkg::CRC_STAGES:0]   ready;

  // A stage takes new data when it is empty or its successor takes its data.
  assign ready[rdfb_pkg::CRC_STAGES] = out_ready;
  assign in_ready                    = ready[0];
  assign out_valid                   = stg_valid[rdfb_pkg::CRC_STAGES-1];
  assign out_frame                   = stg_frame[rdfb_pkg::CRC_STAGES-1];

  for (genvar s = 0; s < rdfb_pkg::CRC_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src_valid[s] = in_valid;
      assign src_frame[s] = in_frame;
    end else begin : g_rest
      assign src_valid[s] = stg_valid[s-1];
      assign src_frame[s] = stg_frame[s-1];
    end

    assign ready[s] = !stg_valid[s] || ready[s+1];

    // Feed this stage's eight stream bits: the frame bits, then eight zeros.
    always_comb begin : crc_step
      rdfb_pkg::frame_t nxt;
      nxt = src_frame[s];
      for (int j = 0; j < rdfb_pkg::CHUNK_W; j++) begin
        if ((s * rdfb_pkg::CHUNK_W + j) < (int'(src_frame[s].len) + rdfb_pkg::CRC_W)) begin
          nxt.crc = rdfb_pkg::crc_bit(nxt.crc,
              src_frame[s].bits[rdfb_pkg::FRAME_W-1-(s*rdfb_pkg::CHUNK_W+j)]);
        end
      end
      stg_next[s] = nxt;
    end

    // Stage registers move only when the stage is ready.
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s] <= 1'b0;
      end else if (ready[s]) begin
        stg_valid[s] <= src_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[s] && src_valid[s]) begin
        stg_frame[s] <= stg_next[s];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rail_decoder_frame_builder.sv =====
// Top level: request capture, CRC pipeline and chunk output stage.
//
// Usage: a request transaction on req_* carries a frame type and its fields;
// each drive request yields six 8-bit chunks, each station broadcast and SID
// request nine chunks, the last one short (7 or 5 bits), flagged by last.
// Frame type 3 is accepted and produces no chunks. The station UID register
// is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// An accepted request passes one capture stage, nine CRC stages of eight
// bits each and the output stage before its first chunk is shown.
// The output stage sends one chunk per cycle while chunk_stall is low.
// A new request is accepted every cycle while the pipeline has room.
// Reset (rst, synchronous) empties all stages, drops chunks in flight and
// clears the station UID to zero.
// When the receiver raises chunk_stall the current chunk holds; the
// pipeline fills up behind it and then raises req_stall.
`default_nettype none

module rail_decoder_frame_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  loco_addr,
  input  wire logic        direction,
  input  wire logic [6:0]  speed_step,
  input  wire logic [15:0] function_bits,
  input  wire logic [31:0] decoder_uid,
  input  wire logic [7:0]  reg_count,
  output logic             chunk_valid,
  input  wire logic        chunk_stall,
  output logic [7:0]       chunk_bits,
  output logic [3:0]       chunk_count,
  output logic             last
);

  logic [31:0]                    station_uid;
  logic                           s0_valid;
  rdfb_pkg::frame_t               s0_frame;
  rdfb_pkg::frame_t               s0_next;
  logic                           s0_known;
  logic                           s0_ready;
  logic                           pipe_in_ready;
  logic                           pipe_valid;
  rdfb_pkg::frame_t               pipe_frame;
  logic                           ser_ready;
  logic [rdfb_pkg::FRAME_W-1:0]   ser_bits;
  logic [rdfb_pkg::FRAME_W-1:0]   ser_bits_next;
  logic [rdfb_pkg::CNT_W-1:0]     ser_left;
  logic [rdfb_pkg::CNT_W-1:0]     ser_left_next;
  logic [rdfb_pkg::CNT_W-1:0]     ser_tail;
  logic [rdfb_pkg::CNT_W-1:0]     ser_tail_next;
  logic [rdfb_pkg::LEN_W-1:0]     total_bits;
  logic [rdfb_pkg::LEN_W-1:0]     total_round;

  // Station UID register.
  always_ff @(posedge clk) begin
    if (rst) begin
      station_uid <= '0;
    end else if (cfg_wr_en) begin
      station_uid <= cfg_wr_data;
    end
  end

  // Assemble the frame left aligned; unused low bits stay zero.
  always_comb begin
    s0_next.crc = rdfb_pkg::CRC_INIT;
    s0_known    = 1'b1;
    case (rdfb_pkg::req_t'(req_type))
      rdfb_pkg::REQ_DRIVE: begin
        s0_next.bits = {2'b10, loco_addr, 3'b001, direction, speed_step, 4'b0111,
                        function_bits, 32'd0};
        s0_next.len  = rdfb_pkg::DRIVE_BITS;
      end
      rdfb_pkg::REQ_STATION: begin
        s0_next.bits = {2'b10, 7'd0, rdfb_pkg::CMD_STATION, station_uid,
                        rdfb_pkg::BCAST_MARK, 8'(reg_count + 8'd1), 9'd0};
        s0_next.len  = rdfb_pkg::STATION_BITS;
      end
      rdfb_pkg::REQ_SID: begin
        s0_next.bits = {2'b10, 7'd0, rdfb_pkg::CMD_SID, 7'd0, loco_addr,
                        decoder_uid, 11'd0};
        s0_next.len  = rdfb_pkg::SID_BITS;
      end
      default: begin
        s0_next.bits = '0;
        s0_next.len  = '0;
        s0_known     = 1'b0;
      end
    endcase
  end

  // Capture stage; an unknown frame type is taken and dropped here.
  assign s0_ready  = !s0_valid || pipe_in_ready;
  assign req_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= req_valid && s0_known;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && req_valid) begin
      s0_frame <= s0_next;
    end
  end

  rdfb_crc_pipe u_crc_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .in_frame  (s0_frame),
    .in_ready  (pipe_in_ready),
    .out_valid (pipe_valid),
    .out_frame (pipe_frame),
    .out_ready (ser_ready)
  );

  // Chunk bookkeeping for the frame leaving the CRC pipeline.
  assign total_bits  = 7'(pipe_frame.len + 7'(rdfb_pkg::CRC_W));
  assign total_round = 7'(total_bits + 7'd7);

  // The output stage loads a new frame when empty or when its last chunk is taken.
  assign ser_ready = (ser_left == '0) || ((ser_left == 4'd1) && !chunk_stall);

  always_comb begin
    ser_bits_next = ser_bits;
    ser_left_next = ser_left;
    ser_tail_next = ser_tail;
    if (ser_ready) begin
      if (pipe_valid) begin
        ser_bits_next = pipe_frame.bits |
                        ({pipe_frame.crc, 64'd0} >> pipe_frame.len);
        ser_left_next = rdfb_pkg::CNT_W'(total_round >> 3);
        ser_tail_next = (total_bits[2:0] == 3'd0) ? 4'd8 : {1'b0, total_bits[2:0]};
      end else begin
        ser_left_next = '0;
      end
    end else if (chunk_valid && !chunk_stall) begin
      ser_bits_next = {ser_bits[rdfb_pkg::FRAME_W-rdfb_pkg::CHUNK_W-1:0],
                       {rdfb_pkg::CHUNK_W{1'b0}}};
      ser_left_next = 4'(ser_left - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_left <= '0;
    end else begin
      ser_left <= ser_left_next;
    end
  end

  always_ff @(posedge clk) begin
    ser_bits <= ser_bits_next;
    ser_tail <= ser_tail_next;
  end

  // Output transaction fields.
  assign chunk_valid = (ser_left != '0);
  assign last        = (ser_left == 4'd1);
  assign chunk_bits  = ser_bits[rdfb_pkg::FRAME_W-1 -: rdfb_pkg::CHUNK_W];
  assign chunk_count = last ? ser_tail : 4'd8;

  // A short chunk only ever closes a frame.
  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (chunk_valid && (chunk_count != 4'd8)) |-> last)
    else $error("short chunk not marked last");

  // Reset leaves no chunk pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !chunk_valid)
    else $error("chunk pending after reset");

  // A taken chunk that is not last is followed by another chunk.
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (chunk_valid && !chunk_stall && !last) |=> chunk_valid)
    else $error("frame ended early");

  // An unknown frame type never enters the pipeline.
  a_drop_unknown: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !(req_type == rdfb_pkg::REQ_DRIVE ||
     req_type == rdfb_pkg::REQ_STATION || req_type == rdfb_pkg::REQ_SID)) |=> !s0_valid)
    else $error("unknown request entered pipeline");

endmodule

`default_nettype wire
